[hdl/cbcr_pkg.sv]
// ---------------------------------------------------------------------------
// cbcr_pkg
// shared types, sizes and helpers for the convex border contain/reflect core
// ---------------------------------------------------------------------------
package cbcr_pkg;

  localparam int MAX_BORDERS = 16;
  localparam int MAX_EDGES   = 8;
  localparam int BORDER_W    = 4;
  localparam int EDGE_W      = 3;
  localparam int COUNT_W     = 4;
  localparam int SLOTS       = MAX_BORDERS * MAX_EDGES;
  localparam int ADDR_W      = BORDER_W + EDGE_W;

  localparam int MUL_A_W = 37;
  localparam int MUL_B_W = 16;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int WIDE_W  = 42;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [BORDER_W-1:0] border_index;
    logic [EDGE_W-1:0]   edge_index;
    logic                last_edge;
    logic signed [31:0]  mid_x;
    logic signed [31:0]  mid_y;
    logic signed [15:0]  normal_x;
    logic signed [15:0]  normal_y;
    logic signed [31:0]  pos_x;
    logic signed [31:0]  pos_y;
    logic signed [31:0]  vel_x;
    logic signed [31:0]  vel_y;
  } in_t;

  typedef struct packed {
    logic               inside_res;
    logic               reflected;
    logic               no_edge;
    logic [EDGE_W-1:0]  hit_edge;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
  } out_t;

  typedef struct packed {
    logic signed [31:0] mid_x;
    logic signed [31:0] mid_y;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
  } edge_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_LAT, ST_D0, ST_D1, ST_V0, ST_V1, ST_EV,
    ST_R0, ST_R1, ST_R2, ST_R3, ST_R4, ST_R5, ST_DONE
  } state_e;

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(signed'(32'sh7fffffff));
    lo = -hi - WIDE_W'(1);
    if (x > hi) return 32'sh7fffffff;
    else if (x < lo) return 32'sh80000000;
    else return x[31:0];
  endfunction

endpackage

[hdl/cbcr_ram.sv]
// ---------------------------------------------------------------------------
// cbcr_ram
// single port generic ram with registered read
// ---------------------------------------------------------------------------
module cbcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[hdl/convex_border_contain_reflect_core.sv]
// ---------------------------------------------------------------------------
// convex_border_contain_reflect_core
// convex border table with containment test and specular reflection
// ---------------------------------------------------------------------------
// channel | direction | handshake               | payload
// in      | request   | in_valid_i / in_stall_o  | in_data_i  (in_t)
// out     | result    | out_valid_o / out_stall_i| out_data_o (out_t)
//
// a load request gives no result
// a query walks every edge of the border in turn and then the reflection when one is
// due, paced by the single shared 37x16 multiplier and the one-read edge ram
// reset clears the edge counts; the edge ram needs no clearing
// the result waits in an output register, so a stalled result only holds
// back the next query at its final step
// ---------------------------------------------------------------------------
module convex_border_contain_reflect_core
  import cbcr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  state_e state_q, state_d;

  // edge counts per border
  logic [COUNT_W-1:0] count_q [MAX_BORDERS];

  // query registers
  logic [BORDER_W-1:0] border_q;
  logic [COUNT_W-1:0]  count_cur_q;
  logic [COUNT_W-1:0]  idx_q;
  logic signed [31:0]  px_q, py_q, vx_q, vy_q;
  edge_t               ent_q;
  logic signed [PROD_W-1:0] prod_q, acc_q, dist_q;
  logic                inside_q, found_q;
  logic [PROD_W-1:0]   best_q;
  logic [EDGE_W-1:0]   hit_q;
  logic signed [15:0]  bnx_q, bny_q;
  logic signed [PROD_W-1:0] bvn_q;
  logic signed [MUL_A_W-1:0] vn16_q, d16_q;
  logic signed [31:0]  npx_q, npy_q, nvx_q, nvy_q;

  out_t out_q;
  logic out_valid_q;

  logic accept;
  logic ram_we;
  logic [ADDR_W-1:0] ram_addr;
  edge_t ram_wdata, ram_rdata;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [32:0]        diff_x, diff_y;
  logic signed [PROD_W-1:0]  sum_now;
  logic [PROD_W-1:0]         abs_d;
  logic signed [PROD_W-1:0]  rnd_prod;
  logic signed [WIDE_W-1:0]  rterm;
  logic out_load;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // edge ram: written by loads, read along the walk
  assign ram_we    = accept && (in_data_i.mode == MODE_LOAD);
  assign ram_addr  = ram_we ? {in_data_i.border_index, in_data_i.edge_index}
                            : {border_q, idx_q[EDGE_W-1:0]};
  assign ram_wdata = '{mid_x: in_data_i.mid_x, mid_y: in_data_i.mid_y,
                       normal_x: in_data_i.normal_x, normal_y: in_data_i.normal_y};

  cbcr_ram #(.WIDTH($bits(edge_t)), .DEPTH(SLOTS)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // shared multiplier operand select
  assign diff_x = 33'(px_q) - 33'(ent_q.mid_x);
  assign diff_y = 33'(py_q) - 33'(ent_q.mid_y);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_D0: begin mul_a = MUL_A_W'(diff_x); mul_b = ent_q.normal_x; end
      ST_D1: begin mul_a = MUL_A_W'(diff_y); mul_b = ent_q.normal_y; end
      ST_V0: begin mul_a = MUL_A_W'(vx_q);   mul_b = ent_q.normal_x; end
      ST_V1: begin mul_a = MUL_A_W'(vy_q);   mul_b = ent_q.normal_y; end
      ST_R1: begin mul_a = vn16_q; mul_b = bnx_q; end
      ST_R2: begin mul_a = vn16_q; mul_b = bny_q; end
      ST_R3: begin mul_a = d16_q;  mul_b = bnx_q; end
      ST_R4: begin mul_a = d16_q;  mul_b = bny_q; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_d  = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign sum_now = acc_q + prod_q;
  assign abs_d   = (dist_q < 0) ? PROD_W'(-dist_q) : PROD_W'(dist_q);
  // round half up of 2*prod by 2^14, i.e. of prod by 2^13
  assign rnd_prod = (prod_q + PROD_W'(4096)) >>> 13;
  assign rterm    = rnd_prod[WIDE_W-1:0];

  // next state
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_data_i.mode == MODE_QUERY) begin
          state_d = (count_q[in_data_i.border_index] == '0) ? ST_R0 : ST_RD;
        end
      end
      ST_RD:  state_d = ST_LAT;
      ST_LAT: state_d = ST_D0;
      ST_D0:  state_d = ST_D1;
      ST_D1:  state_d = ST_V0;
      ST_V0:  state_d = ST_V1;
      ST_V1:  state_d = ST_EV;
      ST_EV:  state_d = (idx_q + COUNT_W'(1) == count_cur_q) ? ST_R0 : ST_RD;
      ST_R0:  state_d = (inside_q && found_q) ? ST_R1 : ST_DONE;
      ST_R1:  state_d = ST_R2;
      ST_R2:  state_d = ST_R3;
      ST_R3:  state_d = ST_R4;
      ST_R4:  state_d = ST_R5;
      ST_R5:  state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int b = 0; b < MAX_BORDERS; b++) count_q[b] <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (ram_we && in_data_i.last_edge) begin
        count_q[in_data_i.border_index] <= COUNT_W'(in_data_i.edge_index) + COUNT_W'(1);
      end
    end
  end

  // query datapath
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (state_q)
      ST_IDLE: begin
        border_q    <= in_data_i.border_index;
        count_cur_q <= count_q[in_data_i.border_index];
        idx_q       <= '0;
        px_q <= in_data_i.pos_x;
        py_q <= in_data_i.pos_y;
        vx_q <= in_data_i.vel_x;
        vy_q <= in_data_i.vel_y;
        inside_q <= 1'b1;
        found_q  <= 1'b0;
        hit_q    <= '0;
        best_q   <= '0;
      end
      ST_LAT: ent_q <= ram_rdata;
      ST_D1:  acc_q <= prod_q;
      ST_V0:  dist_q <= sum_now;
      ST_V1:  acc_q <= prod_q;
      ST_EV: begin
        if (dist_q > 0) inside_q <= 1'b0;
        // nearest edge with v.n <= 0, lowest index on a tie
        if (sum_now <= 0 && (!found_q || abs_d < best_q)) begin
          found_q <= 1'b1;
          best_q  <= abs_d;
          hit_q   <= idx_q[EDGE_W-1:0];
          bnx_q   <= ent_q.normal_x;
          bny_q   <= ent_q.normal_y;
          bvn_q   <= sum_now;
        end
        idx_q <= idx_q + COUNT_W'(1);
      end
      ST_R0: begin
        vn16_q <= MUL_A_W'((bvn_q + PROD_W'(8192)) >>> 14);
        d16_q  <= MUL_A_W'((best_q + PROD_W'(8192)) >> 14);
        npx_q <= px_q;
        npy_q <= py_q;
        nvx_q <= vx_q;
        nvy_q <= vy_q;
      end
      ST_R2: nvx_q <= sat32(WIDE_W'(vx_q) - rterm);
      ST_R3: nvy_q <= sat32(WIDE_W'(vy_q) - rterm);
      ST_R4: npx_q <= sat32(WIDE_W'(px_q) + rterm);
      ST_R5: npy_q <= sat32(WIDE_W'(py_q) + rterm);
      default: begin
      end
    endcase
    if (out_load) begin
      out_q.inside_res <= inside_q;
      out_q.reflected  <= inside_q && found_q;
      out_q.no_edge    <= inside_q && !found_q;
      out_q.hit_edge   <= (inside_q && found_q) ? hit_q : '0;
      out_q.new_pos_x  <= npx_q;
      out_q.new_pos_y  <= npy_q;
      out_q.new_vel_x  <= nvx_q;
      out_q.new_vel_y  <= nvy_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hdl/cbcr_checker.sv]
// ---------------------------------------------------------------------------
// cbcr_checker
// port level checks of the convex border core, bound to the top level
// ---------------------------------------------------------------------------
module cbcr_checker
  import cbcr_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a query keeps the block busy for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.mode == MODE_QUERY |=> in_stall_o)
    else $error("query did not occupy the core");

  // reflection and no-edge only for an inside agent, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.reflected && out_data_o.no_edge) &&
      (out_data_o.inside_res || (!out_data_o.reflected && !out_data_o.no_edge)))
    else $error("inconsistent result flags");

  // hit edge is zero without a reflection
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.reflected |-> out_data_o.hit_edge == '0)
    else $error("hit edge set without reflection");

endmodule

bind convex_border_contain_reflect_core cbcr_checker u_cbcr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[tb/sv/cbcr_reflect_checker.sv]
// ---------------------------------------------------------------------------
// cbcr_reflect_checker
// watches both channels, predicts each query result and compares it
// ---------------------------------------------------------------------------
module cbcr_reflect_checker
  import cbcr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  output int   errors_o,
  output int   pending_o,
  output int   reflected_o,
  output int   no_edge_o,
  output int   outside_o
);
  timeunit 1ns;
  timeprecision 1ps;

  edge_t             border_edge [SLOTS];
  logic [COUNT_W-1:0] border_count [MAX_BORDERS];
  out_t              expected_results [$];

  function automatic logic signed [31:0] clamp_q16(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic out_t predict_reflection(in_t q);
    longint px, py, vx, vy, nx, ny, d, vn, best, vn16, d16;
    int     n, hit, s;
    bit     in_border, found;
    out_t   r;
    px = q.pos_x; py = q.pos_y; vx = q.vel_x; vy = q.vel_y;
    n = border_count[q.border_index];
    if (n > MAX_EDGES) n = MAX_EDGES;
    in_border = 1'b1; found = 1'b0; best = 0; hit = 0;
    for (int i = 0; i < n; i++) begin
      s = q.border_index * MAX_EDGES + i;
      nx = border_edge[s].normal_x; ny = border_edge[s].normal_y;
      d = (px - longint'(border_edge[s].mid_x)) * nx
        + (py - longint'(border_edge[s].mid_y)) * ny;
      if (d > 0) in_border = 1'b0;
    end
    r = '0;
    r.new_pos_x = q.pos_x; r.new_pos_y = q.pos_y;
    r.new_vel_x = q.vel_x; r.new_vel_y = q.vel_y;
    r.inside_res = in_border;
    if (in_border) begin
      // nearest edge facing the velocity, lowest index on a tie
      for (int i = 0; i < n; i++) begin
        s = q.border_index * MAX_EDGES + i;
        nx = border_edge[s].normal_x; ny = border_edge[s].normal_y;
        d = (px - longint'(border_edge[s].mid_x)) * nx
          + (py - longint'(border_edge[s].mid_y)) * ny;
        vn = vx * nx + vy * ny;
        if (d < 0) d = -d;
        if (vn <= 0 && (!found || d < best)) begin
          found = 1'b1; best = d; hit = i;
        end
      end
      if (found) begin
        s = q.border_index * MAX_EDGES + hit;
        nx = border_edge[s].normal_x; ny = border_edge[s].normal_y;
        vn16 = (vx * nx + vy * ny + 64'sd8192) >>> 14;
        d16  = (best + 64'sd8192) >>> 14;
        r.new_vel_x = clamp_q16(vx - ((2 * vn16 * nx + 64'sd8192) >>> 14));
        r.new_vel_y = clamp_q16(vy - ((2 * vn16 * ny + 64'sd8192) >>> 14));
        r.new_pos_x = clamp_q16(px + ((2 * d16 * nx + 64'sd8192) >>> 14));
        r.new_pos_y = clamp_q16(py + ((2 * d16 * ny + 64'sd8192) >>> 14));
        r.reflected = 1'b1;
        r.hit_edge  = hit[EDGE_W-1:0];
      end else begin
        r.no_edge = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report(string field, longint exp_v, longint act_v);
    $display("%0t mismatch %s expected %0d actual %0d", $time, field, exp_v, act_v);
    errors_o++;
  endtask

  initial begin
    errors_o = 0; reflected_o = 0; no_edge_o = 0; outside_o = 0;
  end

  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    int   s;
    if (!rst_ni) begin
      for (int b = 0; b < MAX_BORDERS; b++) border_count[b] = '0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.mode == MODE_LOAD) begin
          s = in_data_i.border_index * MAX_EDGES + in_data_i.edge_index;
          border_edge[s].mid_x    = in_data_i.mid_x;
          border_edge[s].mid_y    = in_data_i.mid_y;
          border_edge[s].normal_x = in_data_i.normal_x;
          border_edge[s].normal_y = in_data_i.normal_y;
          if (in_data_i.last_edge)
            border_count[in_data_i.border_index] =
              COUNT_W'(in_data_i.edge_index) + COUNT_W'(1);
        end else begin
          expected_results.push_back(predict_reflection(in_data_i));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result %h", $time, out_data_i);
          errors_o++;
        end else begin
          want = expected_results.pop_front();
          if (want.reflected) reflected_o++;
          if (want.no_edge) no_edge_o++;
          if (!want.inside_res) outside_o++;
          if (want.inside_res !== out_data_i.inside_res)
            report("inside_res", want.inside_res, out_data_i.inside_res);
          if (want.reflected !== out_data_i.reflected)
            report("reflected", want.reflected, out_data_i.reflected);
          if (want.no_edge !== out_data_i.no_edge)
            report("no_edge", want.no_edge, out_data_i.no_edge);
          if (want.hit_edge !== out_data_i.hit_edge)
            report("hit_edge", want.hit_edge, out_data_i.hit_edge);
          if (want.new_pos_x !== out_data_i.new_pos_x)
            report("new_pos_x", want.new_pos_x, out_data_i.new_pos_x);
          if (want.new_pos_y !== out_data_i.new_pos_y)
            report("new_pos_y", want.new_pos_y, out_data_i.new_pos_y);
          if (want.new_vel_x !== out_data_i.new_vel_x)
            report("new_vel_x", want.new_vel_x, out_data_i.new_vel_x);
          if (want.new_vel_y !== out_data_i.new_vel_y)
            report("new_vel_y", want.new_vel_y, out_data_i.new_vel_y);
        end
      end
    end
  end

endmodule

[tb/sv/tb_convex_border_contain_reflect_core.sv]
// ---------------------------------------------------------------------------
// tb_convex_border_contain_reflect_core
// drives border loads and agent queries with random gaps and stalls; the
// checker beside the core predicts and compares every query result
// ---------------------------------------------------------------------------
module tb_convex_border_contain_reflect_core;
  import cbcr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ITEMS    = 550;
  localparam int IDLE_LIMIT = 3000;  // covers the longest query plus the long result hold-off
  localparam int DRAIN_WAIT = 100;
  localparam int IN_BITS    = $bits(in_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int errors, pending, n_reflected, n_no_edge, n_outside;
  int n_loads = 0, n_queries = 0, n_sent = 0, rx_seen = 0;
  int idle_cycles = 0;

  // what the sender knows of each border, so no unwritten edge is ever read
  int     edge_cnt [MAX_BORDERS];
  bit [7:0] edge_written [MAX_BORDERS];
  longint centre_x [MAX_BORDERS], centre_y [MAX_BORDERS], radius [MAX_BORDERS];

  // eight outward directions in Q2.14
  int dir_x [8] = '{16384, 11585, 0, -11585, -16384, -11585, 0, 11585};
  int dir_y [8] = '{0, 11585, 16384, 11585, 0, -11585, -16384, -11585};

  convex_border_contain_reflect_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  cbcr_reflect_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .errors_o    (errors),
    .pending_o   (pending),
    .reflected_o (n_reflected),
    .no_edge_o   (n_no_edge),
    .outside_o   (n_outside)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog: cycles in which neither channel moves a request or result
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stall per result, one long hold-off mid run
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (rx_seen == 120) gap = 300;
      else if ((rx_seen / 40) % 3 == 2) gap = 0;  // stretch with no stall
      else gap = $urandom_range(0, 5);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      rx_seen++;
    end
  end

  // one request through the handshake, with a random gap ahead of it
  task automatic send_req(in_t r);
    int gap;
    if ((n_sent / 50) % 4 == 3) gap = 0;
    else gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    n_sent++;
    if (r.mode == MODE_LOAD) begin
      n_loads++;
      edge_written[r.border_index][r.edge_index] = 1'b1;
      if (r.last_edge) edge_cnt[r.border_index] = r.edge_index + 1;
    end else begin
      n_queries++;
    end
  endtask

  function automatic in_t noise_req();
    in_t r;
    r = IN_BITS'({$urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom});
    r.normal_x = 16'($urandom_range(0, 32768) - 16384);
    r.normal_y = 16'($urandom_range(0, 32768) - 16384);
    return r;
  endfunction

  task automatic load_edge(int b, int e, bit last, longint mx, longint my, int nx, int ny);
    in_t r;
    r = noise_req();
    r.mode = MODE_LOAD;
    r.border_index = b[BORDER_W-1:0];
    r.edge_index = e[EDGE_W-1:0];
    r.last_edge = last;
    r.mid_x = mx[31:0]; r.mid_y = my[31:0];
    r.normal_x = nx[15:0]; r.normal_y = ny[15:0];
    send_req(r);
  endtask

  task automatic query(int b, longint px, longint py, longint vx, longint vy);
    in_t r;
    r = noise_req();
    r.mode = MODE_QUERY;
    r.border_index = b[BORDER_W-1:0];
    r.pos_x = px[31:0]; r.pos_y = py[31:0];
    r.vel_x = vx[31:0]; r.vel_y = vy[31:0];
    send_req(r);
  endtask

  // well-formed border: edges written in order, the final one marked last
  task automatic load_polygon(int b);
    int n, k;
    longint cx, cy, rad;
    n = ($urandom_range(0, 3) == 0) ? 8 : $urandom_range(3, 5);
    cx = longint'(signed'($urandom)) >>> $urandom_range(2, 8);
    cy = longint'(signed'($urandom)) >>> $urandom_range(2, 8);
    rad = $urandom_range(1, 1 << 20);
    centre_x[b] = cx; centre_y[b] = cy; radius[b] = rad;
    k = $urandom_range(0, 7);
    for (int i = 0; i < n; i++) begin
      k = (k + $urandom_range(1, 2)) % 8;
      load_edge(b, i, i == n - 1, cx + rad * dir_x[k] / 16384,
                cy + rad * dir_y[k] / 16384, dir_x[k], dir_y[k]);
    end
  endtask

  function automatic bit border_ready(int b);
    for (int i = 0; i < edge_cnt[b]; i++)
      if (!edge_written[b][i]) return 1'b0;
    return 1'b1;
  endfunction

  initial begin
    int b;
    longint px, py, vx, vy, off;
    bit drained;
    drained = 1'b0;
    for (int i = 0; i < MAX_BORDERS; i++) begin
      edge_cnt[i] = 0; edge_written[i] = '0;
      centre_x[i] = 0; centre_y[i] = 0; radius[i] = 1 << 16;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: square of half width 10 on border 0
    radius[0] = 10 << 16;
    load_edge(0, 0, 0, 10 << 16, 0, 16384, 0);
    load_edge(0, 1, 0, 0, 10 << 16, 0, 16384);
    load_edge(0, 2, 0, -(10 << 16), 0, -16384, 0);
    load_edge(0, 3, 1, 0, -(10 << 16), 0, -16384);
    query(0, 3 << 16, 1 << 16, -(2 << 16), 0);      // inside, reflects off +x
    query(0, 0, 0, -1, -1);                           // distance tie, lowest wins
    query(0, 20 << 16, 0, 1, 1);                      // outside
    query(0, 10 << 16, 0, 0, 0);                      // on the edge, still inside
    query(5, 123, -456, 789, -1);                     // empty border
    // single half plane: velocity pointing out of it gives no edge
    load_edge(2, 0, 1, 0, 0, 16384, 0);
    query(2, -1, 0, 1 << 16, 0);
    // extremes: saturation of both position and velocity
    load_edge(1, 0, 1, 64'sd2147483647, 64'sd2147483647, 16384, 0);
    query(1, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 64'sd2147483647);
    load_edge(3, 0, 0, -64'sd2147483648, 0, -16384, 0);
    load_edge(3, 1, 1, 0, -64'sd2147483648, 0, -16384);
    query(3, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647);
    load_edge(15, 7, 1, 0, 0, 11585, -11585);
    for (int i = 0; i < 7; i++) load_edge(15, i, 0, 0, 0, -16384, 16384);
    query(15, 0, 0, -64'sd2147483648, -64'sd2147483648);

    // random part
    while (n_sent < N_ITEMS) begin
      if (!drained && n_sent >= 350) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      b = $urandom_range(0, MAX_BORDERS - 1);
      case ($urandom_range(0, 19))
        0, 1, 2: load_polygon(b);
        3: begin
          // stray load with random content, may leave the border unusable
          in_t r;
          r = noise_req();
          r.mode = MODE_LOAD;
          send_req(r);
        end
        default: begin
          if (!border_ready(b)) load_polygon(b);
          off = radius[b];
          if ($urandom_range(0, 9) < 7) begin
            px = centre_x[b] + longint'($urandom_range(0, 2 * off)) - off;
            py = centre_y[b] + longint'($urandom_range(0, 2 * off)) - off;
          end else begin
            px = longint'(signed'($urandom));
            py = longint'(signed'($urandom));
          end
          if ($urandom_range(0, 9) < 6) begin
            vx = longint'(signed'($urandom)) >>> 12;
            vy = longint'(signed'($urandom)) >>> 12;
          end else begin
            vx = longint'(signed'($urandom));
            vy = longint'(signed'($urandom));
          end
          query(b, px, py, vx, vy);
        end
      endcase
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("run covered %0d loads and %0d queries", n_loads, n_queries);
    $display("queries: %0d reflected, %0d without a facing edge, %0d outside",
             n_reflected, n_no_edge, n_outside);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
